### rtl/bacd_pkg.sv
// Package for the bit-aligned codeword detector.
// Holds the command codes, field widths and the controller/datapath interface structs.
// Depends on nothing.
package bacd_pkg;

  localparam int WORD_W    = 16;
  localparam int BUF_W     = 23;
  localparam int BYTE_W    = 8;
  localparam int NUM_SHIFT = 8;
  localparam int SHIFT_W   = 3;
  localparam int PREFIX_POS = 12;
  localparam logic [3:0] PREFIX_VAL = 4'b1110;

  localparam logic [1:0] CMD_DATA  = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef struct packed {
    logic take_byte;
    logic load_word;
    logic clear_book;
    logic rd_en;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic k_last;
    logic out_free;
  } dp_status_t;

endpackage

### rtl/bacd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the codebook store. Depends on nothing.
module bacd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/bacd_ctrl.sv
// Controller state machine for the codeword detector.
// Sequences word intake, the codebook scan and result emission; uses bacd_pkg.
module bacd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  input  logic [1:0]             cmd,
  output logic                   s_tready,
  input  bacd_pkg::dp_status_t   status,
  output bacd_pkg::ctrl_cmd_t    ctrl
);
  import bacd_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          case (cmd)
            CMD_DATA: begin
              ctrl.take_byte = 1'b1;
              state_next = status.count_zero ? ST_EMIT : ST_SCAN;
            end
            CMD_LOAD:  ctrl.load_word = 1'b1;
            CMD_CLEAR: ctrl.clear_book = 1'b1;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        ctrl.rd_en = 1'b1;
        if (status.scan_last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_EMIT;
      ST_EMIT: begin
        if (status.out_free) begin
          ctrl.emit = 1'b1;
          if (status.k_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### rtl/bacd_datapath.sv
// Datapath of the codeword detector: bit buffer, codebook store and count,
// scan compare against all eight windows, and the output register. Uses bacd_pkg, bacd_ram.
module bacd_datapath #(
  parameter int CODEBOOK_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [bacd_pkg::BYTE_W-1:0]   data_byte,
  input  logic [bacd_pkg::WORD_W-1:0]   code_word,
  input  logic                          cfg_we,
  input  logic [bacd_pkg::WORD_W-1:0]   cfg_data,
  input  bacd_pkg::ctrl_cmd_t           ctrl,
  output bacd_pkg::dp_status_t          status,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [23:0]                   m_tdata,
  output logic                          m_tlast
);
  import bacd_pkg::*;

  localparam int CW = $clog2(CODEBOOK_DEPTH + 1);
  localparam int AW = (CODEBOOK_DEPTH > 1) ? $clog2(CODEBOOK_DEPTH) : 1;

  logic [BUF_W-1:0]     bit_buf;
  logic [WORD_W-1:0]    target;
  logic [CW-1:0]        count;
  logic [CW-1:0]        idx;
  logic                 rd_pending;
  logic [NUM_SHIFT-1:0] found_vec;
  logic [SHIFT_W-1:0]   k;
  logic [WORD_W-1:0]    rd_data;
  logic                 full;
  logic [SHIFT_W-1:0]   shift;
  logic [WORD_W-1:0]    win;

  assign full = (count == CW'(CODEBOOK_DEPTH));

  bacd_ram #(
    .WIDTH(WORD_W),
    .DEPTH(CODEBOOK_DEPTH),
    .AW   (AW)
  ) u_book (
    .clk  (clk),
    .we   (ctrl.load_word && !full),
    .waddr(count[AW-1:0]),
    .wdata(code_word),
    .re   (ctrl.rd_en),
    .raddr(idx[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_buf    <= '0;
      target     <= '0;
      count      <= '0;
      rd_pending <= 1'b0;
      m_tvalid   <= 1'b0;
    end else begin
      rd_pending <= ctrl.rd_en;
      if (cfg_we) begin
        target <= cfg_data;
      end
      if (ctrl.take_byte) begin
        bit_buf <= {bit_buf[BUF_W-BYTE_W-1:0], data_byte};
      end
      if (ctrl.clear_book) begin
        count <= '0;
      end else if (ctrl.load_word && !full) begin
        count <= count + CW'(1);
      end
      if (ctrl.emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.take_byte) begin
      idx       <= '0;
      k         <= '0;
      found_vec <= '0;
    end else begin
      if (ctrl.rd_en) begin
        idx <= idx + CW'(1);
      end
      if (ctrl.emit) begin
        k <= k + SHIFT_W'(1);
      end
      if (rd_pending) begin
        for (int j = 0; j < NUM_SHIFT; j++) begin
          if (bit_buf[(NUM_SHIFT - 1 - j) +: WORD_W] == rd_data &&
              rd_data[WORD_W-1:PREFIX_POS] == PREFIX_VAL) begin
            found_vec[j] <= 1'b1;
          end
        end
      end
    end
  end

  assign shift = SHIFT_W'(NUM_SHIFT - 1) - k;
  assign win   = bit_buf[shift +: WORD_W];

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      m_tdata <= {3'b000, (win == target), (found_vec[k] ? win : WORD_W'(0)),
                  found_vec[k], shift};
      m_tlast <= (k == SHIFT_W'(NUM_SHIFT - 1));
    end
  end

  assign status.count_zero = (count == '0);
  assign status.scan_last  = (idx == count - CW'(1));
  assign status.k_last     = (k == SHIFT_W'(NUM_SHIFT - 1));
  assign status.out_free   = !m_tvalid || m_tready;

endmodule

### rtl/bit_aligned_codeword_detector.sv
// Top level of the bit-aligned codeword detector.
// Joins the controller and the datapath; uses bacd_pkg, bacd_ctrl, bacd_datapath.
//
// Usage: the slave stream carries one command word at a time. tuser selects the
// command: a data byte, a codebook load, or a codebook clear. A load appends
// code_word to the codebook unless it is full; a clear empties it. Both
// produce no output. A data byte is shifted into a 23-bit buffer and
// produces eight output words, for right shifts 7 down to 0, with tlast on the
// eighth. Each reports whether the 16-bit window starts with 1110 and is in the
// codebook, and whether it equals the target word written on cfg_we/cfg_data.
// A data byte is scanned against all codebook entries, one entry per cycle
// through the RAM read port, with all eight windows compared at once. After
// the scan state, a drain state lets the last read be compared, and the emit
// state then loads the eight words in turn, each only while the output register
// is free (with an empty codebook the scan is skipped and emission starts directly).
// Reset clears the buffer, the codebook count, the target and the output valid.
// The output is a register: when the receiver stalls, the block holds the word
// and waits; the next command is accepted once all eight words are loaded.
module bit_aligned_codeword_detector #(
  parameter int CODEBOOK_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // data_byte [7:0], code_word [23:8]
  input  logic [1:0]  s_tuser,  // cmd [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // bit_shift [2:0], window_found [3], found_word [19:4], target_hit [20], zeros [23:21]
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data
);
  import bacd_pkg::*;

  ctrl_cmd_t  ctrl;
  dp_status_t status;

  bacd_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .cmd     (s_tuser),
    .s_tready(s_tready),
    .status  (status),
    .ctrl    (ctrl)
  );

  bacd_datapath #(
    .CODEBOOK_DEPTH(CODEBOOK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .data_byte(s_tdata[7:0]),
    .code_word(s_tdata[23:8]),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .ctrl     (ctrl),
    .status   (status),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

### sim/tb_bit_aligned_codeword_detector.sv
// Testbench for bit_aligned_codeword_detector: drives command words with random gaps and
// checks every output word against a cycle-free model of the windows and the codebook.
// Depends on bacd_pkg and the RTL of the block.
module tb_bit_aligned_codeword_detector;
  import bacd_pkg::*;

  localparam int BOOK_DEPTH = 256;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  data_byte;
    logic [15:0] code_word;
  } stream_item_t;

  typedef struct packed {
    logic [2:0]  shift;
    logic        found;
    logic [15:0] word;
    logic        hit;
    logic        last;
  } window_result_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_data = '0;

  stream_item_t   pending[$];
  stream_item_t   offered;
  window_result_t results_due[$];
  window_result_t due_now;
  logic [15:0]    planted_words[$];

  logic [22:0] bit_window = '0;
  logic [15:0] book[BOOK_DEPTH];
  int          book_len = 0;
  logic [15:0] target_q = '0;

  int err_count = 0;
  int tx_gap = 0;
  int rx_gap = 0;
  int rx_hold_left = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;

  bit_aligned_codeword_detector #(
    .CODEBOOK_DEPTH(BOOK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 9);
    return $urandom_range(12, 40);
  endfunction

  function automatic void report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endfunction

  function automatic void predict_windows(input stream_item_t it);
    logic [15:0]    w;
    logic           member;
    window_result_t r;
    case (it.cmd)
      CMD_LOAD: begin
        if (book_len < BOOK_DEPTH) begin
          book[book_len] = it.code_word;
          book_len++;
        end
      end
      CMD_CLEAR: begin
        book_len = 0;
      end
      CMD_DATA: begin
        bit_window = {bit_window[14:0], it.data_byte};
        for (int s = 7; s >= 0; s--) begin
          w = bit_window[s +: 16];
          member = 1'b0;
          for (int i = 0; i < book_len; i++) begin
            if (book[i] == w) member = 1'b1;
          end
          r.shift = s[2:0];
          r.found = (w[15:12] == PREFIX_VAL) && member;
          r.word = r.found ? w : 16'h0000;
          r.hit = (w == target_q);
          r.last = (s == 0);
          results_due.push_back(r);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (s_tvalid && s_tready) predict_windows(offered);
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending.size() != 0) begin
          offered = pending.pop_front();
          s_tuser <= offered.cmd;
          s_tdata <= {offered.code_word, offered.data_byte};
          s_tvalid <= 1'b1;
          if (!tx_steady && $urandom_range(0, 1) == 1) tx_gap = gap_length();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (results_due.size() == 0) begin
          report_error($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
        end else begin
          due_now = results_due.pop_front();
          if (m_tdata[2:0] !== due_now.shift)
            report_error($sformatf("bit_shift want %0d got %0d", due_now.shift, m_tdata[2:0]));
          if (m_tdata[3] !== due_now.found)
            report_error($sformatf("window_found want %b got %b at shift %0d",
                                   due_now.found, m_tdata[3], due_now.shift));
          if (m_tdata[19:4] !== due_now.word)
            report_error($sformatf("found_word want %h got %h at shift %0d",
                                   due_now.word, m_tdata[19:4], due_now.shift));
          if (m_tdata[20] !== due_now.hit)
            report_error($sformatf("target_hit want %b got %b at shift %0d",
                                   due_now.hit, m_tdata[20], due_now.shift));
          if (m_tdata[23:21] !== 3'b000)
            report_error($sformatf("padding want 0 got %b", m_tdata[23:21]));
          if (m_tlast !== due_now.last)
            report_error($sformatf("tlast want %b got %b at shift %0d",
                                   due_now.last, m_tlast, due_now.shift));
        end
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
        rx_gap = gap_length() - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic push(input logic [1:0] c, input logic [7:0] b, input logic [15:0] w);
    stream_item_t it;
    it.cmd = c;
    it.data_byte = b;
    it.code_word = w;
    pending.push_back(it);
  endtask

  // Sends three data bytes whose last 23 bits hold cw at a random bit offset,
  // optionally with one bit of the codeword flipped.
  task automatic plant(input logic [15:0] cw, input logic flip);
    logic [23:0] x;
    int          s;
    int          b;
    x = 24'($urandom);
    s = $urandom_range(0, 7);
    x[s +: 16] = cw;
    if (flip) begin
      b = s + $urandom_range(0, 15);
      x[b] = ~x[b];
    end
    push(CMD_DATA, x[23:16], 16'($urandom));
    push(CMD_DATA, x[15:8], 16'($urandom));
    push(CMD_DATA, x[7:0], 16'($urandom));
  endtask

  task automatic queue_mixed(input int n);
    int          made;
    int          r;
    logic [15:0] cw;
    made = 0;
    while (made < n) begin
      r = $urandom_range(0, 99);
      cw = 16'($urandom);
      cw[15:12] = PREFIX_VAL;
      if (r < 12 && planted_words.size() < 16) begin
        planted_words.push_back(cw);
        push(CMD_LOAD, 8'($urandom), cw);
        made++;
      end else if (r < 55) begin
        if (planted_words.size() != 0)
          cw = planted_words[$urandom_range(0, planted_words.size() - 1)];
        plant(cw, 1'b0);
        made += 3;
      end else if (r < 62) begin
        plant(target_q, 1'b0);
        made += 3;
      end else if (r < 80) begin
        push(CMD_DATA, 8'($urandom), 16'($urandom));
        made++;
      end else if (r < 86) begin
        push(CMD_LOAD, 8'($urandom), 16'($urandom));
        made++;
      end else if (r < 90) begin
        planted_words.delete();
        push(CMD_CLEAR, 8'($urandom), 16'($urandom));
        made++;
      end else if (r < 95) begin
        push(CMD_UNUSED, 8'($urandom), 16'($urandom));
      end else begin
        if (planted_words.size() != 0)
          cw = planted_words[$urandom_range(0, planted_words.size() - 1)];
        plant(cw, 1'b1);
        made += 3;
      end
    end
  endtask

  task automatic write_target(input logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    target_q = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every word is sent and answered, and then lets loads and
  // clears finish inside the block.
  task automatic settle();
    while (pending.size() != 0 || s_tvalid || results_due.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  initial begin
    logic [15:0] first_entry;
    logic [15:0] last_entry;
    logic [15:0] cw;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    tx_steady = 1'b1;
    rx_steady = 1'b1;
    push(CMD_DATA, 8'h00, 16'h0000);
    push(CMD_DATA, 8'hFF, 16'hFFFF);
    push(CMD_UNUSED, 8'hFF, 16'hFFFF);
    push(CMD_CLEAR, 8'h00, 16'h0000);
    push(CMD_LOAD, 8'hFF, 16'hE000);
    push(CMD_LOAD, 8'h00, 16'hEFFF);
    push(CMD_LOAD, 8'h00, 16'hFFFF);
    push(CMD_LOAD, 8'h00, 16'h0000);
    push(CMD_LOAD, 8'h00, 16'hE000);
    push(CMD_DATA, 8'h70, 16'h0000);
    push(CMD_DATA, 8'h00, 16'h0000);
    push(CMD_DATA, 8'h00, 16'h0000);
    push(CMD_DATA, 8'hEF, 16'h0000);
    push(CMD_DATA, 8'hFF, 16'h0000);
    push(CMD_DATA, 8'hFF, 16'h0000);
    push(CMD_DATA, 8'hFF, 16'h0000);
    push(CMD_DATA, 8'h00, 16'h0000);
    push(CMD_DATA, 8'h00, 16'h0000);
    push(CMD_CLEAR, 8'h00, 16'h0000);
    push(CMD_DATA, 8'h70, 16'h0000);
    push(CMD_DATA, 8'h00, 16'h0000);
    push(CMD_DATA, 8'h00, 16'h0000);
    settle();

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    write_target(16'hFFFF);
    queue_mixed(25);
    settle();
    queue_mixed(25);
    settle();

    // Fill the codebook to capacity; the extra loads must be dropped.
    planted_words.delete();
    push(CMD_CLEAR, 8'($urandom), 16'($urandom));
    first_entry = 16'hE000;
    last_entry = 16'hE000;
    for (int i = 0; i < BOOK_DEPTH; i++) begin
      cw = 16'($urandom);
      cw[15:12] = PREFIX_VAL;
      if (i == 0) first_entry = cw;
      last_entry = cw;
      push(CMD_LOAD, 8'($urandom), cw);
    end
    push(CMD_LOAD, 8'($urandom), 16'hE5A5);
    push(CMD_LOAD, 8'($urandom), 16'hEA5A);
    plant(last_entry, 1'b0);
    plant(16'hE5A5, 1'b0);
    plant(first_entry, 1'b0);
    push(CMD_CLEAR, 8'($urandom), 16'($urandom));
    plant(first_entry, 1'b0);
    settle();

    write_target(first_entry);
    @(negedge clk);
    rx_hold_left = 600;
    queue_mixed(30);
    settle();

    write_target(16'h0000);
    tx_steady = 1'b1;
    queue_mixed(25);
    settle();

    tx_steady = 1'b0;
    rx_steady = 1'b1;
    write_target(16'($urandom));
    queue_mixed(25);
    settle();

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("FAIL");
    $finish;
  end

endmodule
